@@ sv/ktsamp_pkg.sv @@
`default_nettype none
package ktsamp_pkg;

  // default track capacity
  localparam int MAX_KEYS_DEF = 64;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // fixed field widths
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int DATA_W  = 32;

  // fraction bits of the interpolation factor
  localparam int FRAC_BITS = 16;

  // vector components per key
  localparam int NUM_COMP = 3;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_LATE  = 2'd2,
    STATUS_EARLY = 2'd3
  } status_t;

  // classified command passed from front to back
  typedef struct packed {
    logic                     is_sample;
    logic                     write_ok;
    logic [INDEX_W-1:0]       key_index;
    logic [DATA_W-1:0]        time_req;
    logic signed [DATA_W-1:0] value_x;
    logic signed [DATA_W-1:0] value_y;
    logic signed [DATA_W-1:0] value_z;
  } cmd_t;

endpackage
`default_nettype wire

@@ sv/ktsamp_front.sv @@
`default_nettype none
module ktsamp_front #(
  parameter int MAX_KEYS = ktsamp_pkg::MAX_KEYS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  kind,
  input  logic [ktsamp_pkg::INDEX_W-1:0]        key_index,
  input  logic [ktsamp_pkg::DATA_W-1:0]         time_req,
  input  logic signed [ktsamp_pkg::DATA_W-1:0]  value_x,
  input  logic signed [ktsamp_pkg::DATA_W-1:0]  value_y,
  input  logic signed [ktsamp_pkg::DATA_W-1:0]  value_z,
  output logic                                  q_push,
  output ktsamp_pkg::cmd_t                      q_data,
  input  logic                                  q_full
);
  import ktsamp_pkg::*;

  logic hold_valid;
  cmd_t hold;
  cmd_t cmd_in;
  logic take;

  // classify the incoming item
  always_comb begin
    cmd_in.is_sample = kind;
    cmd_in.write_ok  = (32'(key_index) < 32'(MAX_KEYS));
    cmd_in.key_index = key_index;
    cmd_in.time_req  = time_req;
    cmd_in.value_x   = value_x;
    cmd_in.value_y   = value_y;
    cmd_in.value_z   = value_z;
  end

  // hold stage stalls only when the queue cannot take its item
  assign in_stall = hold_valid && q_full;
  assign take     = in_valid && !in_stall;
  assign q_push   = hold_valid;
  assign q_data   = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (hold_valid && !q_full) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= cmd_in;
    end
  end

endmodule
`default_nettype wire

@@ sv/ktsamp_queue.sv @@
`default_nettype none
module ktsamp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ktsamp_pkg::cmd_t push_data,
  output logic             full,
  output logic             head_valid,
  output ktsamp_pkg::cmd_t head,
  input  logic             pop
);
  import ktsamp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push_ok;
  logic          pop_ok;

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign push_ok    = push && !full;
  assign pop_ok     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CW'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/ktsamp_back.sv @@
`default_nettype none
module ktsamp_back #(
  parameter int MAX_KEYS = ktsamp_pkg::MAX_KEYS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [ktsamp_pkg::COUNT_W-1:0]        key_count,
  input  logic                                  head_valid,
  input  ktsamp_pkg::cmd_t                      head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ktsamp_pkg::DATA_W-1:0]  out_x,
  output logic signed [ktsamp_pkg::DATA_W-1:0]  out_y,
  output logic signed [ktsamp_pkg::DATA_W-1:0]  out_z,
  output logic [1:0]                            status
);
  import ktsamp_pkg::*;

  localparam int IW        = $clog2(MAX_KEYS);
  localparam int CW        = $clog2(MAX_KEYS + 1);
  localparam int QW        = FRAC_BITS + 1;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int SW        = $clog2(DIV_STEPS + 1);
  localparam int PRW       = DATA_W + 1 + QW + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_RD0  = 8'b0000_0100,
    S_RD1  = 8'b0000_1000,
    S_RD2  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_MUL  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state;

  // key memories
  logic [DATA_W-1:0]        key_times   [MAX_KEYS];
  logic signed [DATA_W-1:0] key_x_store [MAX_KEYS];
  logic signed [DATA_W-1:0] key_y_store [MAX_KEYS];
  logic signed [DATA_W-1:0] key_z_store [MAX_KEYS];

  logic [DATA_W-1:0]        time_rd;
  logic signed [DATA_W-1:0] x_rd;
  logic signed [DATA_W-1:0] y_rd;
  logic signed [DATA_W-1:0] z_rd;

  logic          we;
  logic          t_re;
  logic          v_re;
  logic [IW-1:0] waddr;
  logic [IW-1:0] taddr;
  logic [IW-1:0] vaddr;

  // sample working registers
  logic [DATA_W-1:0]        t_q;
  logic [DATA_W-1:0]        t0;
  logic [DATA_W-1:0]        t1;
  logic [IW-1:0]            seg;
  logic                     single;
  logic [CW-1:0]            scan_idx;
  logic [CW-1:0]            chk_idx;
  logic                     chk_vld;
  logic signed [DATA_W-1:0] v0  [NUM_COMP];
  logic signed [DATA_W-1:0] v1  [NUM_COMP];
  logic signed [DATA_W-1:0] res [NUM_COMP];
  status_t                  res_status;
  logic [DATA_W:0]          rem;
  logic [DATA_W-1:0]        dvs;
  logic [QW-1:0]            quo;
  logic [SW-1:0]            step;
  logic [1:0]               mcnt;
  logic signed [PRW-1:0]    prod;
  logic signed [DATA_W-1:0] base;

  // derived values
  logic [31:0]              count_wide;
  logic [31:0]              idx_wide;
  logic [CW-1:0]            n;
  logic [CW-1:0]            last_idx;
  logic [CW-1:0]            chk_prev;
  logic [DATA_W+1:0]        diff;
  logic                     borrow;
  logic [DATA_W:0]          rem_keep;
  logic signed [DATA_W:0]   delta;
  logic signed [PRW-1:0]    scaled;
  logic signed [DATA_W-1:0] comp;

  // clamp key count to capacity
  assign count_wide = (32'(key_count) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : 32'(key_count);
  assign n          = count_wide[CW-1:0];
  assign last_idx   = n - CW'(1);
  assign chk_prev   = chk_idx - CW'(1);
  assign idx_wide   = 32'(head.key_index);
  assign waddr      = idx_wide[IW-1:0];

  // restoring divider step
  assign diff     = {1'b0, rem} - {2'b00, dvs};
  assign borrow   = diff[DATA_W+1];
  assign rem_keep = borrow ? rem : diff[DATA_W:0];

  // shared multiplier, component at the head of the rotation
  assign delta  = $signed({v1[0][DATA_W-1], v1[0]}) - $signed({v0[0][DATA_W-1], v0[0]});
  assign scaled = prod >>> FRAC_BITS;
  assign comp   = base + scaled[DATA_W-1:0];

  // memory control
  always_comb begin
    pop   = 1'b0;
    we    = 1'b0;
    t_re  = 1'b0;
    v_re  = 1'b0;
    taddr = '0;
    vaddr = '0;
    case (state)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          we  = !head.is_sample && head.write_ok;
        end
      end
      S_SCAN: begin
        t_re  = (scan_idx < n);
        taddr = scan_idx[IW-1:0];
      end
      S_RD0: begin
        t_re  = 1'b1;
        v_re  = 1'b1;
        taddr = seg;
        vaddr = seg;
      end
      S_RD1: begin
        v_re  = !single;
        vaddr = seg + IW'(1);
      end
      default: ;
    endcase
  end

  // key memories with registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      key_times[waddr]   <= head.time_req;
      key_x_store[waddr] <= head.value_x;
      key_y_store[waddr] <= head.value_y;
      key_z_store[waddr] <= head.value_z;
    end
    if (t_re) begin
      time_rd <= key_times[taddr];
    end
    if (v_re) begin
      x_rd <= key_x_store[vaddr];
      y_rd <= key_y_store[vaddr];
      z_rd <= key_z_store[vaddr];
    end
  end

  // sample sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      chk_vld   <= 1'b0;
    end else begin
      // the finish state reloads the output register itself
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid && head.is_sample) begin
            t_q <= head.time_req;
            res <= '{default: '0};
            if (n == '0) begin
              res_status <= STATUS_EMPTY;
              state      <= S_FIN;
            end else if (n == CW'(1)) begin
              single <= 1'b1;
              seg    <= '0;
              state  <= S_RD0;
            end else begin
              single   <= 1'b0;
              scan_idx <= CW'(1);
              chk_vld  <= 1'b0;
              state    <= S_SCAN;
            end
          end
        end
        // one key time read and checked per cycle
        S_SCAN: begin
          if (chk_vld && (t_q <= time_rd)) begin
            seg     <= chk_prev[IW-1:0];
            t1      <= time_rd;
            chk_vld <= 1'b0;
            state   <= S_RD0;
          end else if (chk_vld && (chk_idx == last_idx)) begin
            res_status <= STATUS_LATE;
            chk_vld    <= 1'b0;
            state      <= S_FIN;
          end else begin
            chk_vld <= (scan_idx < n);
            chk_idx <= scan_idx;
            if (scan_idx < n) begin
              scan_idx <= scan_idx + CW'(1);
            end
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          t0 <= time_rd;
          v0 <= '{x_rd, y_rd, z_rd};
          if (single) begin
            res        <= '{x_rd, y_rd, z_rd};
            res_status <= STATUS_OK;
            state      <= S_FIN;
          end else begin
            state <= S_RD2;
          end
        end
        S_RD2: begin
          v1 <= '{x_rd, y_rd, z_rd};
          if (t_q < t0) begin
            res_status <= STATUS_EARLY;
            state      <= S_FIN;
          end else if (t1 == t0) begin
            quo   <= '0;
            mcnt  <= '0;
            state <= S_MUL;
          end else begin
            rem   <= {1'b0, t_q - t0};
            dvs   <= t1 - t0;
            quo   <= '0;
            step  <= '0;
            state <= S_DIV;
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          quo  <= {quo[QW-2:0], ~borrow};
          rem  <= {rem_keep[DATA_W-1:0], 1'b0};
          step <= step + SW'(1);
          if (step == SW'(DIV_STEPS - 1)) begin
            mcnt  <= '0;
            state <= S_MUL;
          end
        end
        // multiply one component, add the previous one
        S_MUL: begin
          if (mcnt != 2'(NUM_COMP)) begin
            prod <= PRW'(delta * $signed({1'b0, quo}));
            base <= v0[0];
            v0   <= '{v0[1], v0[2], v0[0]};
            v1   <= '{v1[1], v1[2], v1[0]};
          end
          if (mcnt != '0) begin
            res <= '{res[1], res[2], comp};
          end
          mcnt <= mcnt + 2'(1);
          if (mcnt == 2'(NUM_COMP)) begin
            res_status <= STATUS_OK;
            state      <= S_FIN;
          end
        end
        // hand the result to the output register
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_x     <= res[0];
            out_y     <= res[1];
            out_z     <= res[2];
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/keyframe_track_sampler_top.sv @@
`default_nettype none
// Keyframe track sampler: holds up to MAX_KEYS keys (time in unsigned Q24.8,
// xyz in signed Q16.16) and answers sample items with a linearly
// interpolated vector and a status. Items are accepted into a hold register
// and a two-entry queue, so the input keeps flowing while the back end works.
// A write item is popped and written without leaving the idle state. For a
// sample, the segment search reads one key time per cycle through the single
// read port of the time memory, the factor comes from a restoring divider, and
// one shared multiplier handles the three components. The result sits in an
// output register, so the next item is started while it waits. The user must
// write key_count through cfg_we/cfg_wdata only while the block is idle; the
// block does not enforce this; key memories are not cleared at reset and must
// be written before they are sampled.
module keyframe_track_sampler_top #(
  parameter int MAX_KEYS = ktsamp_pkg::MAX_KEYS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ktsamp_pkg::COUNT_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  kind,
  input  logic [ktsamp_pkg::INDEX_W-1:0]        key_index,
  input  logic [ktsamp_pkg::DATA_W-1:0]         time_req,
  input  logic signed [ktsamp_pkg::DATA_W-1:0]  value_x,
  input  logic signed [ktsamp_pkg::DATA_W-1:0]  value_y,
  input  logic signed [ktsamp_pkg::DATA_W-1:0]  value_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ktsamp_pkg::DATA_W-1:0]  out_x,
  output logic signed [ktsamp_pkg::DATA_W-1:0]  out_y,
  output logic signed [ktsamp_pkg::DATA_W-1:0]  out_z,
  output logic [1:0]                            status
);
  import ktsamp_pkg::*;

  logic [COUNT_W-1:0] key_count;
  logic               q_push;
  cmd_t               q_data;
  logic               q_full;
  logic               head_valid;
  cmd_t               head;
  logic               pop;

  // key count register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (cfg_we) begin
      key_count <= cfg_wdata;
    end
  end

  ktsamp_front #(
    .MAX_KEYS (MAX_KEYS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .key_index (key_index),
    .time_req  (time_req),
    .value_x   (value_x),
    .value_y   (value_y),
    .value_z   (value_z),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  ktsamp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ktsamp_back #(
    .MAX_KEYS (MAX_KEYS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .key_count  (key_count),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .status     (status)
  );

endmodule
`default_nettype wire

@@ sim/tb_keyframe_track_sampler_top.sv @@
`default_nettype none
module tb_keyframe_track_sampler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ktsamp_pkg::*;

  localparam int NKEYS = MAX_KEYS_DEF;
  localparam int SETTLE_CYCLES = 200;
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;
  localparam logic [DATA_W-1:0] T_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic              kind;
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } track_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    status_t           st;
  } sample_result_t;

  // dut ports, all inputs known from time zero
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [COUNT_W-1:0]       cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     kind = 1'b0;
  logic [INDEX_W-1:0]       key_index = '0;
  logic [DATA_W-1:0]        time_req = '0;
  logic signed [DATA_W-1:0] value_x = '0;
  logic signed [DATA_W-1:0] value_y = '0;
  logic signed [DATA_W-1:0] value_z = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_x;
  logic signed [DATA_W-1:0] out_y;
  logic signed [DATA_W-1:0] out_z;
  logic [1:0]               status;

  // items waiting to be driven and samples waiting for their result
  track_item_t    item_q[$];
  sample_result_t sample_exp_q[$];

  // predictor copy of the track and the key count
  logic [DATA_W-1:0]  trk_time[NKEYS];
  logic [DATA_W-1:0]  trk_x[NKEYS];
  logic [DATA_W-1:0]  trk_y[NKEYS];
  logic [DATA_W-1:0]  trk_z[NKEYS];
  logic [COUNT_W-1:0] trk_count = '0;

  // key times as generated, used to aim query times
  logic [DATA_W-1:0] gen_time[NKEYS];

  logic no_idle = 1'b0;
  int   fails = 0;

  keyframe_track_sampler_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .key_index (key_index),
    .time_req  (time_req),
    .value_x   (value_x),
    .value_y   (value_y),
    .value_z   (value_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .status    (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one component of the lerp, floor rounding on the scaled delta
  function automatic logic [DATA_W-1:0] lerp_axis(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                                  logic [63:0] f);
    longint s;
    longint d;
    longint p;
    s = longint'(signed'(a));
    d = longint'(signed'(b)) - s;
    p = d * longint'(f);
    return 32'(s + (p >>> 16));
  endfunction

  // expected result of a sample at query time q
  function automatic sample_result_t predict_sample(logic [DATA_W-1:0] q);
    sample_result_t r;
    int             n;
    int             seg;
    bit             found;
    logic [DATA_W-1:0] t0;
    logic [DATA_W-1:0] t1;
    logic [63:0]    f;
    r = '{x: '0, y: '0, z: '0, st: STATUS_OK};
    n = (trk_count > NKEYS) ? NKEYS : int'(trk_count);
    if (n == 0) begin
      r.st = STATUS_EMPTY;
      return r;
    end
    if (n == 1) begin
      r.x = trk_x[0];
      r.y = trk_y[0];
      r.z = trk_z[0];
      return r;
    end
    // first segment whose end time is at or after the query
    found = 1'b0;
    seg = 0;
    for (int i = 0; i + 1 < n; i++) begin
      if (q <= trk_time[i+1]) begin
        seg = i;
        found = 1'b1;
        break;
      end
    end
    if (!found) begin
      r.st = STATUS_LATE;
      return r;
    end
    t0 = trk_time[seg];
    t1 = trk_time[seg+1];
    if (q < t0) begin
      r.st = STATUS_EARLY;
      return r;
    end
    // zero-length span keeps the start value
    if (t1 == t0) f = '0;
    else f = (64'(q - t0) << FRAC_BITS) / 64'(t1 - t0);
    r.x = lerp_axis(trk_x[seg], trk_x[seg+1], f);
    r.y = lerp_axis(trk_y[seg], trk_y[seg+1], f);
    r.z = lerp_axis(trk_z[seg], trk_z[seg+1], f);
    return r;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      fails++;
    end
  endtask

  // driver: predicts on acceptance, then presents the next item or idles
  always @(posedge clk) begin
    track_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (kind == KIND_WRITE) begin
          if (key_index < NKEYS) begin
            trk_time[key_index] = time_req;
            trk_x[key_index] = value_x;
            trk_y[key_index] = value_y;
            trk_z[key_index] = value_z;
          end
        end else begin
          sample_exp_q.insert(sample_exp_q.size(), predict_sample(time_req));
        end
      end
      if (!in_valid || !in_stall) begin
        if (item_q.size() != 0 && (no_idle || $urandom_range(99) >= 28)) begin
          nxt = item_q.pop_front();
          in_valid  <= 1'b1;
          kind      <= nxt.kind;
          key_index <= nxt.idx;
          time_req  <= nxt.t;
          value_x   <= nxt.x;
          value_y   <= nxt.y;
          value_z   <= nxt.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result with the oldest expectation
  always @(posedge clk) begin
    sample_result_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sample_exp_q.size() == 0) begin
          $error("result item with no sample waiting");
          fails++;
        end else begin
          e = sample_exp_q.pop_front();
          check_field("out_x", e.x, out_x);
          check_field("out_y", e.y, out_y);
          check_field("out_z", e.z, out_z);
          check_field("status", 32'(e.st), 32'(status));
        end
      end
      out_stall <= !no_idle && ($urandom_range(99) < 28);
    end
  end

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return {DATA_W{$urandom_range(1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  task automatic push_write(int idx, logic [DATA_W-1:0] t, logic [DATA_W-1:0] x,
                            logic [DATA_W-1:0] y, logic [DATA_W-1:0] z);
    item_q.insert(item_q.size(),
                  '{kind: KIND_WRITE, idx: INDEX_W'(idx), t: t, x: x, y: y, z: z});
    gen_time[idx] = t;
  endtask

  // sample item, unused fields carry noise
  task automatic push_sample(logic [DATA_W-1:0] t);
    item_q.insert(item_q.size(),
                  '{kind: KIND_SAMPLE, idx: INDEX_W'($urandom_range(NKEYS - 1)), t: t,
                    x: $urandom, y: $urandom, z: $urandom});
  endtask

  // wait until every item is in and every result out, then let the back end settle
  task automatic wait_idle();
    @(negedge clk);
    while (item_q.size() != 0 || in_valid || sample_exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_count(logic [COUNT_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    trk_count = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // query time aimed around the keys in use
  function automatic logic [DATA_W-1:0] pick_query(int m);
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    if (m == 0) return $urandom;
    lo = gen_time[0];
    hi = gen_time[m-1];
    case ($urandom_range(9))
      0: return (lo == 0) ? '0 : $urandom_range(0, lo - 1);
      1: return (hi == T_MAX) ? T_MAX : $urandom_range(hi + 1, T_MAX);
      2: return gen_time[$urandom_range(m - 1)];
      3: return $urandom;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // one track setting: fill the keys in use, then mixed writes and samples
  task automatic run_track_phase(int n, bit sorted, int num_ops);
    int m;
    int slot;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] step;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    m = (n > NKEYS) ? NKEYS : n;
    write_key_count(COUNT_W'(n));
    span = ($urandom_range(1) == 1) ? T_MAX : 32'd4000;
    step = span / ((m > 0) ? m : 1);
    cur = $urandom_range(0, step);
    for (int i = 0; i < m; i++) begin
      if (!sorted) cur = $urandom;
      else if (i > 0 && $urandom_range(7) != 0) cur = cur + $urandom_range(0, step);
      push_write(i, cur, rand_value(), rand_value(), rand_value());
    end
    for (int k = 0; k < num_ops; k++) begin
      if ($urandom_range(9) < 3) begin
        slot = $urandom_range(NKEYS - 1);
        if (slot < m && sorted) begin
          // keep the track sorted
          lo = (slot > 0) ? gen_time[slot-1] : '0;
          hi = (slot < m - 1) ? gen_time[slot+1] : T_MAX;
          cur = $urandom_range(lo, hi);
        end else begin
          cur = $urandom;
        end
        push_write(slot, cur, rand_value(), rand_value(), rand_value());
      end else begin
        push_sample(pick_query(m));
      end
    end
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < NKEYS; i++) begin
      trk_time[i] = '0;
      trk_x[i] = '0;
      trk_y[i] = '0;
      trk_z[i] = '0;
      gen_time[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty track, then keys with extreme values
    write_key_count('0);
    push_sample('0);
    push_sample(T_MAX);
    push_write(0, 32'd1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    push_write(1, 32'd1000, 32'd5, 32'd6, 32'd7);
    push_write(2, 32'd3000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_write(3, T_MAX, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    push_write(NKEYS - 1, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle();

    // single key returned whatever the time
    write_key_count(COUNT_W'(1));
    push_sample('0);
    push_sample(T_MAX);
    wait_idle();

    // before first key, zero-length span, interior, segment end, last segment
    write_key_count(COUNT_W'(4));
    push_sample('0);
    push_sample(32'd999);
    push_sample(32'd1000);
    push_sample(32'd2000);
    push_sample(32'd3000);
    push_sample(T_MAX);
    wait_idle();

    // after the last key
    write_key_count(COUNT_W'(3));
    push_sample(T_MAX);
    push_sample(32'd3001);
    wait_idle();

    // random tracks; each phase drains fully before the next setting
    run_track_phase(2, 1'b1, 18);
    wait_idle();
    run_track_phase(NKEYS, 1'b1, 18);
    wait_idle();
    no_idle <= 1'b1;
    run_track_phase(127, 1'b1, 18);
    wait_idle();
    no_idle <= 1'b0;
    run_track_phase(0, 1'b1, 18);
    wait_idle();
    run_track_phase(1, 1'b1, 18);
    wait_idle();
    run_track_phase(3, 1'b1, 18);
    wait_idle();
    run_track_phase($urandom_range(2, NKEYS), 1'b1, 18);
    wait_idle();
    run_track_phase($urandom_range(2, NKEYS), 1'b0, 18);
    wait_idle();
    run_track_phase(5, 1'b1, 18);
    wait_idle();
    run_track_phase(24, 1'b1, 18);
    wait_idle();

    if (sample_exp_q.size() != 0) begin
      $error("%0d sample results never arrived", sample_exp_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run time limit
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
sv/ktsamp_pkg.sv
sv/ktsamp_front.sv
sv/ktsamp_queue.sv
sv/ktsamp_back.sv
sv/keyframe_track_sampler_top.sv
sim/tb_keyframe_track_sampler_top.sv
